/* src/kdb_pkg.sv */
// shared constants and types for the keypad debounce block
package kdb_pkg;

	localparam int NUM_KEYS    = 4;
	localparam int KEY_FIELD_W = 4;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(25);
	localparam logic [CFG_W-1:0] HOLD_RESET     = CFG_W'(1200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = CFG_IDX_W'(0),
		REG_HOLD     = CFG_IDX_W'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic press;
		logic stable;
	} lane_stat_t;

	typedef struct packed {
		logic [KEY_FIELD_W-1:0] press_events;
		logic [KEY_FIELD_W-1:0] stable_keys;
		logic                   combo_flag;
	} result_t;

endpackage

/* src/keypad_debounce_with_hold_combo.sv */
// top level of the keypad debounce and all-keys hold combo block
// One sample is accepted per clock cycle while in_stall is low; its result beat
// is registered in the output or skid register. Each key has its own debounce
// lane with a 32-bit elapsed-time compare, all lanes and the hold timer
// evaluate in the accept cycle, and their state updates on that same edge, so
// consecutive samples stream without gaps. A two-entry output buffer lets the
// block take one more sample while a result waits; stall rises only when both
// entries hold beats. Configuration writes take effect on the next sample.
module keypad_debounce_with_hold_combo
	import kdb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic [KEY_FIELD_W-1:0] raw_keys,
	input  logic                   combo_ack,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [KEY_FIELD_W-1:0] press_events,
	output logic [KEY_FIELD_W-1:0] stable_keys,
	output logic                   combo_flag
);

	logic [CFG_W-1:0]          debounce_q;
	logic [CFG_W-1:0]          hold_q;
	logic                      take;
	logic [NUM_KEYS-1:0]       levels;
	logic                      all_down;
	logic                      combo;
	lane_stat_t [NUM_KEYS-1:0] lane_stat;
	result_t                   result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_HOLD:     hold_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign take     = in_valid && !in_stall;
	assign all_down = &levels;

	genvar i;
	generate
		for (i = 0; i < NUM_KEYS; i++) begin : g_lane
			// keys above the raw field always read released
			if (i < KEY_FIELD_W) begin : g_in
				assign levels[i] = raw_keys[i];
			end else begin : g_off
				assign levels[i] = 1'b0;
			end

			kdb_key_lane u_lane (
				.clk           (clk),
				.arst_n        (arst_n),
				.take          (take),
				.now_ms        (now_ms),
				.level         (levels[i]),
				.debounce_time (debounce_q),
				.stat          (lane_stat[i])
			);
		end
	endgenerate

	kdb_combo u_combo (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.now_ms    (now_ms),
		.all_down  (all_down),
		.combo_ack (combo_ack),
		.hold_time (hold_q),
		.flag      (combo)
	);

	kdb_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.lane_stat (lane_stat),
		.all_down  (all_down),
		.combo     (combo),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign press_events = result.press_events;
	assign stable_keys  = result.stable_keys;
	assign combo_flag   = result.combo_flag;

endmodule

/* src/kdb_key_lane.sv */
// debounce lane for one key
module kdb_key_lane
	import kdb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              level,
	input  logic [CFG_W-1:0]  debounce_time,
	output lane_stat_t        stat
);

	logic              state_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] elapsed;
	logic              change;

	// modulo 2^32 time since the last accepted change
	assign elapsed = now_ms - last_q;
	assign change  = (level != state_q) && (elapsed > TIME_W'(debounce_time));

	assign stat.press  = change && level;
	assign stat.stable = change ? level : state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 1'b0;
			last_q  <= '0;
		end else if (take && change) begin
			state_q <= level;
			last_q  <= now_ms;
		end
	end

endmodule

/* src/kdb_combo.sv */
// all-keys hold timer and sticky combo flag
module kdb_combo
	import kdb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              all_down,
	input  logic              combo_ack,
	input  logic [CFG_W-1:0]  hold_time,
	output logic              flag
);

	logic [TIME_W-1:0] start_q;
	logic              sticky_q;
	logic [TIME_W-1:0] held;
	logic              started;

	// zero start time means the hold has not started
	assign started = (start_q != '0);
	assign held    = now_ms - start_q;
	assign flag    = sticky_q || (all_down && started && (held > TIME_W'(hold_time)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			sticky_q <= 1'b0;
		end else if (take) begin
			if (!all_down) begin
				start_q <= '0;
			end else if (!started) begin
				start_q <= now_ms;
			end
			sticky_q <= flag && !combo_ack;
		end
	end

endmodule

/* src/kdb_merge.sv */
// merges lane results into one beat and buffers it with a skid stage
module kdb_merge
	import kdb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  lane_stat_t [NUM_KEYS-1:0] lane_stat,
	input  logic                      all_down,
	input  logic                      combo,
	output logic                      full,
	output logic                      out_valid,
	input  logic                      out_stall,
	output result_t                   result
);

	result_t merged;
	result_t main_q;
	result_t skid_q;
	logic    main_valid_q;
	logic    skid_valid_q;
	logic    pop;

	genvar j;
	generate
		for (j = 0; j < KEY_FIELD_W; j++) begin : g_bit
			if (j < NUM_KEYS) begin : g_key
				// presses are suppressed when every key is down
				assign merged.press_events[j] = lane_stat[j].press && !all_down;
				assign merged.stable_keys[j]  = lane_stat[j].stable;
			end else begin : g_pad
				assign merged.press_events[j] = 1'b0;
				assign merged.stable_keys[j]  = 1'b0;
			end
		end
	endgenerate
	assign merged.combo_flag = combo;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign result    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : merged;
		end else if (take) begin
			skid_q <= merged;
		end
	end

endmodule

/* src/kdb_checker.sv */
// port-level checks for the keypad debounce block, bound to the top level
module kdb_checker
	import kdb_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [KEY_FIELD_W-1:0] press_events,
	input logic [KEY_FIELD_W-1:0] stable_keys,
	input logic                   combo_flag
);

	// a held beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(press_events)
			&& $stable(stable_keys) && $stable(combo_flag))
		else $error("stalled result beat changed");

	// a press always leaves its key debounced down
	a_press_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_events & ~stable_keys) == '0)
		else $error("press event on a key not debounced down");

	// with all keys down presses are suppressed, so all four never fire together
	a_no_full_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> press_events != {KEY_FIELD_W{1'b1}})
		else $error("press events on every key at once");

	// input stalls only when a result is already waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind keypad_debounce_with_hold_combo kdb_checker u_kdb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.press_events (press_events),
	.stable_keys  (stable_keys),
	.combo_flag   (combo_flag)
);
